// ===== sv/rgbh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the RGB channel histogram: sizes, command codes, item types and
// the count arithmetic shared by the interfaces and the top level.
// Depends on nothing.

package rgbh_pkg;

    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 32;
    localparam int OUT_BITS   = 32;
    localparam int IDX_W      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
    localparam logic [1:0] CMD_READ       = 2'd1;
    localparam logic [1:0] CMD_CLEAR      = 2'd2;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [IDX_W-1:0]      t_addr;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] red_value;
        logic [7:0] green_value;
        logic [7:0] blue_value;
        logic [7:0] bin_index;
    } t_in_item;

    typedef struct packed {
        logic [OUT_BITS-1:0] red_count;
        logic [OUT_BITS-1:0] green_count;
        logic [OUT_BITS-1:0] blue_count;
        logic [OUT_BITS-1:0] all_count;
    } t_out_item;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ALL,
        S_READ
    } t_state;

    function automatic logic sample_in_range(input logic [7:0] v);
        return 32'(v) < 32'(BIN_COUNT);
    endfunction

    function automatic t_addr sample_addr(input logic [7:0] v);
        logic [IDX_W+7:0] w;
        w = {{IDX_W{1'b0}}, v};
        return w[IDX_W-1:0];
    endfunction

    // Saturating add of a small increment (one to three).
    function automatic t_count sat_add(input t_count c, input logic [1:0] k);
        logic [COUNT_BITS:0] s;
        s = {1'b0, c} + {{(COUNT_BITS-1){1'b0}}, k};
        if (s[COUNT_BITS]) begin
            return '1;
        end
        return s[COUNT_BITS-1:0];
    endfunction

    // Clamp a count to the width of the result fields.
    function automatic logic [OUT_BITS-1:0] to_out(input t_count c);
        logic [COUNT_BITS+OUT_BITS-1:0] w;
        w = {{OUT_BITS{1'b0}}, c};
        if (w > {{COUNT_BITS{1'b0}}, {OUT_BITS{1'b1}}}) begin
            return '1;
        end
        return w[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/rgbh_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Command channel of the RGB channel histogram: valid/ready plus one command item.
// Depends on rgbh_pkg.

interface rgbh_in_if import rgbh_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/rgbh_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the RGB channel histogram: valid/ready plus the four bin counts.
// Depends on rgbh_pkg.

interface rgbh_out_if import rgbh_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/rgb_channel_histogram_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the RGB channel histogram: sequencer around four bin RAMs.
// Depends on rgbh_pkg, rgbh_in_if, rgbh_out_if and rgbh_ram.
//
//  Channel  Direction  Transaction carries
//  i_pix    in         command, red/green/blue samples, bin index
//  o_res    out        red, green, blue and combined counts of one bin
//
// An accumulate is accepted, then makes one read-modify-write of the combined
// histogram per sample, since that RAM has a single write port.
// A read is accepted, then waits in S_READ while the result register is still occupied.
// Reset and a clear command sweep all BIN_COUNT entries, one per cycle, while
// i_pix.ready stays low. An unused command code is accepted and dropped.
// The result register lets a new transaction be accepted while a result waits.

module rgb_channel_histogram_unit import rgbh_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rgbh_in_if.sink    i_pix,
    rgbh_out_if.source o_res
);

    t_state    r_state, n_state;
    logic [1:0] r_step, n_step;
    t_addr     r_clr_addr, n_clr_addr;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic [7:0] r_smp [3];
    logic      r_bin_oob;

    logic      in_ready;
    logic      in_acc;

    logic [2:0] ch_we;
    logic [2:0] ch_re;
    t_addr     ch_waddr [3];
    t_addr     ch_raddr [3];
    t_count    ch_wdata [3];
    t_count    ch_rdata [3];

    logic      all_we, all_re;
    t_addr     all_waddr, all_raddr;
    t_count    all_wdata, all_rdata;

    logic [7:0] cur_smp, nxt_smp;
    logic [1:0] nxt_step;
    logic [1:0] cur_k;
    logic      cur_active;
    logic [7:0] in_smp [3];

    assign in_acc = i_pix.valid && in_ready;
    assign i_pix.ready = in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign in_smp[0] = i_pix.data.red_value;
    assign in_smp[1] = i_pix.data.green_value;
    assign in_smp[2] = i_pix.data.blue_value;

    for (genvar j = 0; j < 3; j++) begin : g_ch
        rgbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_ch_ram (
            .i_clk   (i_clk),
            .i_we    (ch_we[j]),
            .i_waddr (ch_waddr[j]),
            .i_wdata (ch_wdata[j]),
            .i_re    (ch_re[j]),
            .i_raddr (ch_raddr[j]),
            .o_rdata (ch_rdata[j])
        );
    end

    rgbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_all_ram (
        .i_clk   (i_clk),
        .i_we    (all_we),
        .i_waddr (all_waddr),
        .i_wdata (all_wdata),
        .i_re    (all_re),
        .i_raddr (all_raddr),
        .o_rdata (all_rdata)
    );

    // A sample that repeats an earlier one of the same pixel is folded into the
    // earlier step, which adds the full number of matches at once.
    assign nxt_step = r_step + 2'd1;
    assign cur_smp  = r_smp[r_step];
    assign nxt_smp  = r_smp[(r_step == 2'd0) ? 2'd1 : 2'd2];
    assign cur_k    = 2'(r_smp[0] == cur_smp) + 2'(r_smp[1] == cur_smp)
                    + 2'(r_smp[2] == cur_smp);
    assign cur_active = sample_in_range(cur_smp)
                      && !((r_step != 2'd0) && (r_smp[0] == cur_smp))
                      && !((r_step == 2'd2) && (r_smp[1] == cur_smp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc) begin
            r_smp[0]  <= i_pix.data.red_value;
            r_smp[1]  <= i_pix.data.green_value;
            r_smp[2]  <= i_pix.data.blue_value;
            r_bin_oob <= !sample_in_range(i_pix.data.bin_index);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        in_ready    = 1'b0;
        ch_we       = '0;
        ch_re       = '0;
        all_we      = 1'b0;
        all_re      = 1'b0;
        all_waddr   = sample_addr(cur_smp);
        all_wdata   = sat_add(all_rdata, cur_k);
        all_raddr   = sample_addr(nxt_smp);
        for (int j = 0; j < 3; j++) begin
            ch_waddr[j] = sample_addr(r_smp[j]);
            ch_wdata[j] = sat_add(ch_rdata[j], 2'd1);
            ch_raddr[j] = sample_addr(in_smp[j]);
        end

        case (r_state)
            S_CLEAR: begin
                ch_we     = '1;
                all_we    = 1'b1;
                all_waddr = r_clr_addr;
                all_wdata = '0;
                for (int j = 0; j < 3; j++) begin
                    ch_waddr[j] = r_clr_addr;
                    ch_wdata[j] = '0;
                end
                if (r_clr_addr == t_addr'(BIN_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + t_addr'(1);
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_pix.valid) begin
                    case (i_pix.data.command)
                        CMD_ACCUMULATE: begin
                            ch_re     = '1;
                            all_re    = 1'b1;
                            all_raddr = sample_addr(i_pix.data.red_value);
                            n_step    = 2'd0;
                            n_state   = S_ALL;
                        end
                        CMD_READ: begin
                            ch_re     = '1;
                            all_re    = 1'b1;
                            all_raddr = sample_addr(i_pix.data.bin_index);
                            for (int j = 0; j < 3; j++) begin
                                ch_raddr[j] = sample_addr(i_pix.data.bin_index);
                            end
                            n_state = S_READ;
                        end
                        CMD_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ALL: begin
                if (r_step == 2'd0) begin
                    for (int j = 0; j < 3; j++) begin
                        ch_we[j] = sample_in_range(r_smp[j]);
                    end
                end
                all_we = cur_active;
                if (r_step == 2'd2) begin
                    n_state = S_IDLE;
                end else begin
                    all_re = 1'b1;
                    n_step = nxt_step;
                end
            end
            S_READ: begin
                // RAM read data holds here until the result register frees up.
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    if (r_bin_oob) begin
                        n_out = '0;
                    end else begin
                        n_out.red_count   = to_out(ch_rdata[0]);
                        n_out.green_count = to_out(ch_rdata[1]);
                        n_out.blue_count  = to_out(ch_rdata[2]);
                        n_out.all_count   = to_out(all_rdata);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_pix.ready)
        else $error("transaction accepted during clear sweep");

    a_ch_write_first_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((ch_we != 3'b000) && (r_state != S_CLEAR)) |-> (r_state == S_ALL && r_step == 2'd0))
        else $error("channel RAM written outside the first accumulate step");

    a_read_goes_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_pix.data.command == CMD_READ) |=> (r_state == S_READ))
        else $error("read transaction did not enter result stage");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_READ))
        else $error("result raised without a read");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALL) |-> (r_step != 2'd3))
        else $error("accumulate step out of range");

endmodule

`default_nettype wire

// ===== sv/rgbh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.

module rgbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic                                        i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== tb/rgbh_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the RGB channel histogram: keeps its own four histograms, predicts
// the counts of every bin read and compares them with the result channel.
// Depends on rgbh_pkg, rgbh_in_if and rgbh_out_if.

module rgbh_checker import rgbh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rgbh_in_if        i_pix,
    rgbh_out_if       i_res,
    output int        o_mismatches,
    output int        o_reads_due
);

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALL   = 3;

    localparam logic [OUT_BITS-1:0] OUT_TOP = '1;

    t_count    channel_hist [4][BIN_COUNT];
    t_out_item bin_counts_due [$];

    function automatic t_count count_up(input t_count c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Counts wider than the result fields stick at the largest field value.
    function automatic logic [OUT_BITS-1:0] result_field(input t_count c);
        return (128'(c) > 128'(OUT_TOP)) ? OUT_TOP : OUT_BITS'(c);
    endfunction

    task automatic clear_histograms();
        for (int ch = 0; ch < 4; ch++) begin
            for (int b = 0; b < BIN_COUNT; b++) begin
                channel_hist[ch][b] = '0;
            end
        end
    endtask

    // A sample lands in its own channel and once more in the combined histogram.
    task automatic tally_sample(input int ch, input logic [7:0] v);
        if (32'(v) < BIN_COUNT) begin
            channel_hist[ch][v]     = count_up(channel_hist[ch][v]);
            channel_hist[CH_ALL][v] = count_up(channel_hist[CH_ALL][v]);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                   input logic [OUT_BITS-1:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    task automatic check_field(input string what, input logic [OUT_BITS-1:0] got,
                               input logic [OUT_BITS-1:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_in_item  cmd;
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            clear_histograms();
            bin_counts_due.delete();
            o_mismatches = 0;
        end else begin
            // The result leaving at this edge always belongs to an older read.
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (bin_counts_due.size() == 0) begin
                    report_mismatch("result with no read outstanding", got.red_count, '0);
                end else begin
                    want = bin_counts_due.pop_front();
                    check_field("red count", got.red_count, want.red_count);
                    check_field("green count", got.green_count, want.green_count);
                    check_field("blue count", got.blue_count, want.blue_count);
                    check_field("combined count", got.all_count, want.all_count);
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                cmd = i_pix.data;
                case (cmd.command)
                    CMD_ACCUMULATE: begin
                        tally_sample(CH_RED, cmd.red_value);
                        tally_sample(CH_GREEN, cmd.green_value);
                        tally_sample(CH_BLUE, cmd.blue_value);
                    end
                    CMD_READ: begin
                        want = '0;
                        if (32'(cmd.bin_index) < BIN_COUNT) begin
                            want.red_count   = result_field(channel_hist[CH_RED][cmd.bin_index]);
                            want.green_count =
                                result_field(channel_hist[CH_GREEN][cmd.bin_index]);
                            want.blue_count  = result_field(channel_hist[CH_BLUE][cmd.bin_index]);
                            want.all_count   = result_field(channel_hist[CH_ALL][cmd.bin_index]);
                        end
                        bin_counts_due.push_back(want);
                    end
                    CMD_CLEAR: begin
                        clear_histograms();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_reads_due <= bin_counts_due.size();
    end

endmodule

// ===== tb/rgb_channel_histogram_unit_tb.sv =====
`timescale 1ns / 1ps
// Top of the RGB channel histogram regression: clock, reset, command stimulus and
// result back-pressure. Depends on rgbh_pkg, both channel interfaces, the block and
// rgbh_checker.

module rgb_channel_histogram_unit_tb;
    import rgbh_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_IDLE     = 7;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   reads_due;
    bit   quiet_phase = 1'b0;
    int   result_hold = 0;

    rgbh_in_if  pix_if ();
    rgbh_out_if res_if ();

    rgb_channel_histogram_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    rgbh_checker hist_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .o_mismatches (mismatches),
        .o_reads_due  (reads_due)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #5_000_000;
        $display("rgb_channel_histogram_unit regression: fail");
        $finish;
    end

    // The result side draws a fresh stall length, zero in the quiet phase, after every transaction it takes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_hold = 0;
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                result_hold = quiet_phase ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (result_hold > 0) begin
                result_hold = result_hold - 1;
            end
            res_if.ready <= (result_hold == 0);
        end
    end

    function automatic t_in_item make_item(input logic [1:0] cmd, input logic [7:0] red,
                                           input logic [7:0] green, input logic [7:0] blue,
                                           input logic [7:0] bin);
        t_in_item item;
        item.command     = cmd;
        item.red_value   = red;
        item.green_value = green;
        item.blue_value  = blue;
        item.bin_index   = bin;
        return item;
    endfunction

    // Half the samples come from a few values at each end so that bins grow tall
    // and the same bin is hit back to back.
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 3));
            1: return 8'(252 + $urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_command();
        t_in_item item;
        int       pick;
        logic [7:0] shade;
        item = make_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            item.command = CMD_ACCUMULATE;
            if ($urandom_range(0, 3) == 0) begin
                shade = pick_sample();
                item.red_value   = shade;
                item.green_value = shade;
                item.blue_value  = shade;
            end else begin
                item.red_value   = pick_sample();
                item.green_value = pick_sample();
                item.blue_value  = pick_sample();
            end
        end else if (pick < 92) begin
            item.command   = CMD_READ;
            item.bin_index = pick_sample();
        end else if (pick < 95) begin
            item.command = CMD_CLEAR;
        end
        return item;
    endfunction

    task automatic send_command(input t_in_item item);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= item;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    task automatic drain_results();
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (reads_due != 0);
    endtask

    initial begin
        int       accepted;
        t_in_item item;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        res_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty bins, extreme samples, every command, hazards.
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255));
        send_command(make_item(CMD_ACCUMULATE, 8'd0, 8'd0, 8'd0, 8'($urandom)));
        send_command(make_item(CMD_ACCUMULATE, 8'd255, 8'd255, 8'd255, 8'($urandom)));
        send_command(make_item(CMD_ACCUMULATE, 8'd255, 8'd0, 8'd128, 8'($urandom)));
        send_command(make_item(CMD_ACCUMULATE, 8'hAA, 8'h55, 8'hFF, 8'($urandom)));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd128));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'hAA));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'h55));
        send_command(make_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom)));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0));
        quiet_phase <= 1'b1;
        repeat (3) send_command(make_item(CMD_ACCUMULATE, 8'd7, 8'd7, 8'd7, 8'($urandom)));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd7));
        quiet_phase <= 1'b0;
        send_command(make_item(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom)));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255));
        send_command(make_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd7));

        accepted = 0;
        while (accepted < RANDOM_ITEMS) begin
            if (accepted % 64 == 0) begin
                quiet_phase <= ($urandom_range(0, 3) == 0);
            end
            item = random_command();
            send_command(item);
            if (item.command != CMD_UNUSED) begin
                accepted++;
                // Now and then let every outstanding read come back before going on.
                if (accepted % 250 == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (BIN_COUNT + 16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("rgb_channel_histogram_unit regression: pass");
        end else begin
            $display("rgb_channel_histogram_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rgbh_pkg.sv
sv/rgbh_in_if.sv
sv/rgbh_out_if.sv
sv/rgbh_ram.sv
sv/rgb_channel_histogram_unit.sv
tb/rgbh_checker.sv
tb/rgb_channel_histogram_unit_tb.sv
